>>> rtl/pwo_pkg.sv
package pwo_pkg;

  // Table geometry and number formats.
  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = 10;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = ADDR_W + FRAC_W;
  localparam int SAMPLE_W   = 16;
  localparam int NUM_TABLES = 7;
  localparam int TSEL_W     = 3;
  localparam int VOICE_W    = 2;
  localparam int ACTION_W   = 2;
  localparam int SUB_BASE   = 4;

  // Interpolation arithmetic: fraction (zero-extended) times the signed slope.
  localparam int PROD_W = FRAC_W + SAMPLE_W + 2;

  // The voice that plays its main table alone.
  localparam logic [VOICE_W-1:0] VOICE_SOLO = 2'd3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_REQ   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef struct packed {
    logic                       en;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] data;
  } wave_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } wave_rd_t;

endpackage

>>> rtl/pwo_if.sv
interface pwo_in_if;
  import pwo_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [TSEL_W-1:0]          table_sel;
  logic [ADDR_W-1:0]          table_addr;
  logic signed [SAMPLE_W-1:0] table_word;
  logic [VOICE_W-1:0]         voice;

  modport source (
    output valid, action, table_sel, table_addr, table_word, voice,
    input  ready
  );

  modport sink (
    input  valid, action, table_sel, table_addr, table_word, voice,
    output ready
  );
endinterface

interface pwo_out_if;
  import pwo_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic [VOICE_W-1:0]         voice_out;

  modport source (
    output valid, sample, voice_out,
    input  ready
  );

  modport sink (
    input  valid, sample, voice_out,
    output ready
  );
endinterface

>>> rtl/pwo_wave_ram.sv
module pwo_wave_ram (
  input  logic                                clk_i,
  input  pwo_pkg::wave_wr_t                   wr_i,
  input  pwo_pkg::wave_rd_t                   rd_i,
  output logic signed [pwo_pkg::SAMPLE_W-1:0] rdata_a_o,
  output logic signed [pwo_pkg::SAMPLE_W-1:0] rdata_b_o
);
  import pwo_pkg::*;

  // One wave table: one write port, two read ports with registered data.
  logic signed [SAMPLE_W-1:0] mem_q [TABLE_SIZE];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_a_o <= mem_q[rd_i.addr_a];
      rdata_b_o <= mem_q[rd_i.addr_b];
    end
  end

endmodule

>>> rtl/paired_wavetable_oscillator_core.sv
// Paired wavetable oscillator with linear interpolation.
//
// Items arrive on in_if (valid/ready). A load item writes one signed word into
// one of seven wave tables (0-3 main, 4-6 sub); a clear item zeroes all seven
// phase accumulators; a request item asks for the next sample of a voice.
// Voices 0-2 average their main table with the paired sub table, voice 3 plays
// main table 3 alone. Only requests produce a result item on out_if. The user
// must write the step registers (cfg_we_i / cfg_idx_i / cfg_wdata_i) only while the
// block is idle, which it does not enforce; an index past the last table is ignored.
//
// An accepted request is registered in order: the accept edge latches the table
// reads, the stage 2 registers latch the slope products, and the output register
// holds the interpolated and averaged sample that out_if shows.
// Without a stall, one item is accepted every cycle; the rate is set by the two read
// ports on each table memory, which fetch both interpolation points at once.
// When the receiver stalls, the three stages fill up and in_if.ready falls
// only once all of them hold an item.
// Reset clears the phases, the step registers and the pipeline. Table contents
// are undefined until loaded; no clearing pass is run over the tables.
module paired_wavetable_oscillator_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  pwo_in_if.sink                           in_if,
  pwo_out_if.source                        out_if,
  input  logic                             cfg_we_i,
  input  logic [pwo_pkg::TSEL_W-1:0]       cfg_idx_i,
  input  logic [pwo_pkg::PHASE_W-1:0]      cfg_wdata_i
);
  import pwo_pkg::*;

  // Configuration and phase state.
  logic [NUM_TABLES-1:0][PHASE_W-1:0] step_q;
  logic [NUM_TABLES-1:0][PHASE_W-1:0] phase_q, phase_d;

  // Flow control.
  logic in_fire, req, clr, load;
  logic out_free, s2_free, s1_free;

  // Accept stage decode.
  logic              solo;
  logic [TSEL_W-1:0] main_sel, sub_sel;
  logic [NUM_TABLES-1:0] step_en;

  // Table memories.
  wave_wr_t                   wr [NUM_TABLES];
  wave_rd_t                   rd [NUM_TABLES];
  logic signed [SAMPLE_W-1:0] rda [NUM_TABLES];
  logic signed [SAMPLE_W-1:0] rdb [NUM_TABLES];

  // Stage 1: table data (inside the memories) plus fractions.
  logic               v1_q;
  logic               solo1_q;
  logic [VOICE_W-1:0] voice1_q;
  logic [TSEL_W-1:0]  sub1_q;
  logic [FRAC_W-1:0]  fm1_q, fs1_q;

  logic signed [SAMPLE_W-1:0] am1, bm1, as1, bs1;
  logic signed [PROD_W-1:0]   pm1, ps1;

  // Stage 2: base words and slope products.
  logic                       v2_q;
  logic                       solo2_q;
  logic [VOICE_W-1:0]         voice2_q;
  logic signed [SAMPLE_W-1:0] am2_q, as2_q;
  logic signed [PROD_W-1:0]   pm2_q, ps2_q;

  logic signed [PROD_W-1:0]   accm2, accs2;
  logic signed [SAMPLE_W-1:0] sm2, ss2;
  logic signed [SAMPLE_W:0]   sum2;
  logic signed [SAMPLE_W-1:0] mix2;

  // Output register.
  logic                       ov_q;
  logic [VOICE_W-1:0]         ovoice_q;
  logic signed [SAMPLE_W-1:0] osample_q;

  // Each stage moves on when the one after it is empty or moving.
  assign out_free    = !ov_q || out_if.ready;
  assign s2_free     = !v2_q || out_free;
  assign s1_free     = !v1_q || s2_free;
  assign in_if.ready = s1_free;

  assign in_fire = in_if.valid && s1_free;
  assign req     = in_fire && (in_if.action == ACT_REQ);
  assign clr     = in_fire && (in_if.action == ACT_CLEAR);
  assign load    = in_fire && (in_if.action == ACT_LOAD);

  assign solo     = (in_if.voice == VOICE_SOLO);
  assign main_sel = TSEL_W'(in_if.voice);
  assign sub_sel  = solo ? TSEL_W'(SUB_BASE) : TSEL_W'(SUB_BASE) + TSEL_W'(in_if.voice);

  // A request steps exactly the tables it reads; a clear zeroes all phases.
  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      step_en[t] = req && ((TSEL_W'(t) == main_sel) || (!solo && (TSEL_W'(t) == sub_sel)));
      if (clr) begin
        phase_d[t] = '0;
      end else if (step_en[t]) begin
        phase_d[t] = phase_q[t] + step_q[t];
      end else begin
        phase_d[t] = phase_q[t];
      end
      rd[t].en     = step_en[t];
      rd[t].addr_a = phase_q[t][PHASE_W-1 -: ADDR_W];
      rd[t].addr_b = phase_q[t][PHASE_W-1 -: ADDR_W] + ADDR_W'(1);
      wr[t].en     = load && (in_if.table_sel == TSEL_W'(t));
      wr[t].addr   = in_if.table_addr;
      wr[t].data   = in_if.table_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i < TSEL_W'(NUM_TABLES))) begin
      step_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_table
    pwo_wave_ram u_ram (
      .clk_i     (clk_i),
      .wr_i      (wr[g]),
      .rd_i      (rd[g]),
      .rdata_a_o (rda[g]),
      .rdata_b_o (rdb[g])
    );
  end

  // Stage 1 registers. The memories latch their data on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s1_free) begin
      v1_q <= req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req) begin
      solo1_q  <= solo;
      voice1_q <= in_if.voice;
      sub1_q   <= sub_sel;
      fm1_q    <= phase_q[main_sel][FRAC_W-1:0];
      fs1_q    <= phase_q[sub_sel][FRAC_W-1:0];
    end
  end

  // Slope times fraction for both tables of the pair. Both operands are
  // extended to the full product width so that no bits of the product are lost.
  always_comb begin
    am1 = rda[TSEL_W'(voice1_q)];
    bm1 = rdb[TSEL_W'(voice1_q)];
    as1 = rda[sub1_q];
    bs1 = rdb[sub1_q];
    pm1 = $signed({{(PROD_W-FRAC_W){1'b0}}, fm1_q})
        * ($signed({{(PROD_W-SAMPLE_W){bm1[SAMPLE_W-1]}}, bm1})
         - $signed({{(PROD_W-SAMPLE_W){am1[SAMPLE_W-1]}}, am1}));
    ps1 = $signed({{(PROD_W-FRAC_W){1'b0}}, fs1_q})
        * ($signed({{(PROD_W-SAMPLE_W){bs1[SAMPLE_W-1]}}, bs1})
         - $signed({{(PROD_W-SAMPLE_W){as1[SAMPLE_W-1]}}, as1}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (s2_free) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && s2_free) begin
      solo2_q  <= solo1_q;
      voice2_q <= voice1_q;
      am2_q    <= am1;
      as2_q    <= as1;
      pm2_q    <= pm1;
      ps2_q    <= ps1;
    end
  end

  // The interpolated value always lies between the two table words, so the
  // floor of acc / 2^FRAC_W fits the sample width exactly.
  always_comb begin
    accm2 = {{(PROD_W-SAMPLE_W-FRAC_W){am2_q[SAMPLE_W-1]}}, am2_q, {FRAC_W{1'b0}}} + pm2_q;
    accs2 = {{(PROD_W-SAMPLE_W-FRAC_W){as2_q[SAMPLE_W-1]}}, as2_q, {FRAC_W{1'b0}}} + ps2_q;
    sm2   = accm2[FRAC_W +: SAMPLE_W];
    ss2   = accs2[FRAC_W +: SAMPLE_W];
    sum2  = $signed({sm2[SAMPLE_W-1], sm2}) + $signed({ss2[SAMPLE_W-1], ss2});
    mix2  = solo2_q ? sm2 : sum2[SAMPLE_W:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && out_free) begin
      osample_q <= mix2;
      ovoice_q  <= voice2_q;
    end
  end

  assign out_if.valid     = ov_q;
  assign out_if.sample    = osample_q;
  assign out_if.voice_out = ovoice_q;

`ifndef SYNTH
  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> (phase_q == '0))
    else $error("phases not zero after a clear item");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req || clr) |=> $stable(phase_q))
    else $error("phase changed without a request or clear item");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (v1_q && v2_q && ov_q))
    else $error("input stalled while a stage is empty");

  a_req_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |=> (v1_q && (voice1_q == $past(in_if.voice))))
    else $error("accepted request did not enter the pipeline");
`endif

endmodule
